/* sv/ctrs_pkg.sv */
package ctrs_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int COORD_BITS    = 32;
    localparam int CORDIC_STAGES = 14;

    localparam int TURN_W    = 32;
    localparam int ZI_W      = TURN_W + 1;
    localparam int XY_W      = 32;
    localparam int TRIG_W    = 16;
    localparam int TRIG_ONE  = 16384;
    localparam int TRIG_FRAC = 15;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd326016437;
    localparam int ATAN_COUNT = 24;

    localparam int PROD_W  = 2 * TRIG_W;
    localparam int TRI_W   = PROD_W + TRIG_W;
    localparam int TERM_W  = TRI_W;
    localparam int RMAG_W  = 32;
    localparam int SPROD_W = COORD_BITS + RMAG_W;
    localparam int SMAG_W  = SPROD_W - 30;
    localparam int ELEMS   = 9;

    localparam logic [TURN_W-1:0] ATAN_TURNS [ATAN_COUNT] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
        32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [TRIG_W-1:0]     trig_t;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] yaw_angle;
        logic signed [ANGLE_BITS-1:0] roll_angle;
        coord_t scale_x;
        coord_t scale_y;
        coord_t scale_z;
        coord_t pos_x;
        coord_t pos_y;
        coord_t pos_z;
    } ctrs_in_t;

    typedef struct packed {
        coord_t elem_00;
        coord_t elem_01;
        coord_t elem_02;
        coord_t elem_04;
        coord_t elem_05;
        coord_t elem_06;
        coord_t elem_08;
        coord_t elem_09;
        coord_t elem_10;
        coord_t elem_12;
        coord_t elem_13;
        coord_t elem_14;
    } ctrs_out_t;

    // sine/cosine of all three angles plus the untouched scale and position
    typedef struct packed {
        trig_t  sp;
        trig_t  cp;
        trig_t  sy;
        trig_t  cy;
        trig_t  sr;
        trig_t  cr;
        coord_t scale_x;
        coord_t scale_y;
        coord_t scale_z;
        coord_t pos_x;
        coord_t pos_y;
        coord_t pos_z;
    } ctrs_trig_t;

    // round half away from zero to Q1.14, clamp, undo the half-turn fold
    function automatic trig_t round_trig(input logic signed [XY_W-1:0] v, input logic flip);
        logic [XY_W-1:0]         mag;
        logic [XY_W-1:0]         sum;
        logic [XY_W-TRIG_FRAC-1:0] m;
        trig_t                   res;
        mag = v[XY_W-1] ? XY_W'(-v) : XY_W'(v);
        sum = mag + XY_W'(1 << (TRIG_FRAC - 1));
        m   = sum[XY_W-1:TRIG_FRAC];
        if (m > (XY_W-TRIG_FRAC)'(TRIG_ONE)) begin
            m = (XY_W-TRIG_FRAC)'(TRIG_ONE);
        end
        res = TRIG_W'(m);
        if (v[XY_W-1] ^ flip) begin
            res = -res;
        end
        return res;
    endfunction

endpackage

/* sv/compose_trs_matrix_core.sv */
// Builds the affine matrix Translation*Roll*Yaw*Pitch*Scale from three 16-bit binary angles,
// three Q16.16 scale factors and a Q16.16 position. One word is accepted per clock and one
// result word leaves per clock when the output is not stalled. An accepted word passes through
// the three parallel CORDIC pipelines, the four-word queue between the two halves, and the
// multiply and saturate pipeline, in that order. The queue lets each half stall on its own.
// Elements saturate to the signed Q16.16 range; translation passes through unchanged.
module compose_trs_matrix_core import ctrs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ctrs_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output ctrs_out_t m_data
);

    logic       f_valid, f_ready;
    ctrs_trig_t f_data;
    logic       b_valid, b_ready;
    ctrs_trig_t b_data;

    ctrs_front u_front (
        .aclk (aclk), .aresetn (aresetn),
        .s_valid (s_valid), .s_ready (s_ready), .s_data (s_data),
        .q_valid (f_valid), .q_ready (f_ready), .q_data (f_data)
    );

    ctrs_queue u_queue (
        .aclk (aclk), .aresetn (aresetn),
        .in_valid (f_valid), .in_ready (f_ready), .in_data (f_data),
        .out_valid (b_valid), .out_ready (b_ready), .out_data (b_data)
    );

    ctrs_back u_back (
        .aclk (aclk), .aresetn (aresetn),
        .q_valid (b_valid), .q_ready (b_ready), .q_data (b_data),
        .m_valid (m_valid), .m_ready (m_ready), .m_data (m_data)
    );

endmodule

/* sv/ctrs_cordic.sv */
module ctrs_cordic import ctrs_pkg::*; (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output trig_t                 sin_q,
    output trig_t                 cos_q
);

    logic [TURN_W-1:0]          turn;
    logic                       fold;
    logic signed [ZI_W-1:0]     z_reg [CORDIC_STAGES+1];
    logic signed [XY_W-1:0]     x_reg [CORDIC_STAGES+1];
    logic signed [XY_W-1:0]     y_reg [CORDIC_STAGES+1];
    logic                       fold_reg [CORDIC_STAGES+1];
    trig_t                      sin_reg;
    trig_t                      cos_reg;

    assign turn = {angle, {(TURN_W-ANGLE_BITS){1'b0}}};
    assign fold = turn[TURN_W-1] ^ turn[TURN_W-2];

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg[0]    <= ZI_W'($signed({turn[TURN_W-1] ^ fold, turn[TURN_W-2:0]}));
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            fold_reg[0] <= fold;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[i][ZI_W-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ZI_W'(ATAN_TURNS[i]);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ZI_W'(ATAN_TURNS[i]);
                end
                fold_reg[i+1] <= fold_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= round_trig(x_reg[CORDIC_STAGES], fold_reg[CORDIC_STAGES]);
            sin_reg <= round_trig(y_reg[CORDIC_STAGES], fold_reg[CORDIC_STAGES]);
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

/* sv/ctrs_front.sv */
module ctrs_front import ctrs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  ctrs_in_t   s_data,
    output logic       q_valid,
    input  logic       q_ready,
    output ctrs_trig_t q_data
);

    localparam int DEPTH = CORDIC_STAGES + 2;

    logic       en;
    logic       v_reg [DEPTH];
    ctrs_in_t   side_reg [DEPTH];

    assign en      = !(v_reg[DEPTH-1] && !q_ready);
    assign s_ready = en;
    assign q_valid = v_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= s_valid;
            for (int i = 1; i < DEPTH; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= s_data;
            for (int i = 1; i < DEPTH; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    ctrs_cordic u_pitch (
        .aclk (aclk), .en (en), .angle (s_data.pitch_angle),
        .sin_q (q_data.sp), .cos_q (q_data.cp)
    );
    ctrs_cordic u_yaw (
        .aclk (aclk), .en (en), .angle (s_data.yaw_angle),
        .sin_q (q_data.sy), .cos_q (q_data.cy)
    );
    ctrs_cordic u_roll (
        .aclk (aclk), .en (en), .angle (s_data.roll_angle),
        .sin_q (q_data.sr), .cos_q (q_data.cr)
    );

    assign q_data.scale_x = side_reg[DEPTH-1].scale_x;
    assign q_data.scale_y = side_reg[DEPTH-1].scale_y;
    assign q_data.scale_z = side_reg[DEPTH-1].scale_z;
    assign q_data.pos_x   = side_reg[DEPTH-1].pos_x;
    assign q_data.pos_y   = side_reg[DEPTH-1].pos_y;
    assign q_data.pos_z   = side_reg[DEPTH-1].pos_z;

endmodule

/* sv/ctrs_queue.sv */
module ctrs_queue import ctrs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  ctrs_trig_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output ctrs_trig_t out_data
);

    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);

    ctrs_trig_t       mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [PTR_W:0]   count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != (PTR_W+1)'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PTR_W+1)'(QDEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_reg - rd_reg) == count_reg[PTR_W-1:0])
        else $error("queue pointers disagree with count");
    a_pop_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop without push did not drop count");

endmodule

/* sv/ctrs_back.sv */
module ctrs_back import ctrs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    output logic       q_ready,
    input  ctrs_trig_t q_data,
    output logic       m_valid,
    input  logic       m_ready,
    output ctrs_out_t  m_data
);

    localparam int NST = 7;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [TRI_W-1:0]  tri_t;
    typedef logic signed [TERM_W-1:0] term_t;

    logic   en;
    logic   v_reg [NST];
    coord_t sc_reg  [NST][3];
    coord_t pos_reg [NST][3];

    // stage 1: pair products
    prod_t crcy_reg, cysr_reg, crsp_reg, cpsr_reg, cpcr_reg, spsr_reg, cysp_reg, cpcy_reg;
    trig_t sy1_reg;
    // stage 2: triple products
    prod_t crcy2_reg, cysr2_reg, crsp2_reg, cpsr2_reg, cpcr2_reg, spsr2_reg, cysp2_reg;
    prod_t cpcy2_reg;
    trig_t sy2_reg;
    tri_t  crspsy_reg, spsrsy_reg, cpcrsy_reg, cpsrsy_reg;
    // stage 3 onward: per element
    term_t              term_reg [ELEMS];
    logic [RMAG_W-1:0]  mr_reg   [ELEMS];
    logic               rneg_reg [ELEMS];
    logic [COORD_BITS-1:0] ms_reg [ELEMS];
    logic               sneg_reg [ELEMS];
    logic [SPROD_W-1:0] prod_reg [ELEMS];
    logic               neg5_reg [ELEMS];
    logic [COORD_BITS-1:0] mag_reg [ELEMS];
    logic               neg6_reg [ELEMS];
    coord_t             el_reg   [ELEMS];

    assign en      = !(v_reg[NST-1] && !m_ready);
    assign q_ready = en;
    assign m_valid = v_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NST; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= q_valid;
            for (int i = 1; i < NST; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sc_reg[0][0]  <= q_data.scale_x;
            sc_reg[0][1]  <= q_data.scale_y;
            sc_reg[0][2]  <= q_data.scale_z;
            pos_reg[0][0] <= q_data.pos_x;
            pos_reg[0][1] <= q_data.pos_y;
            pos_reg[0][2] <= q_data.pos_z;
            for (int i = 1; i < NST; i++) begin
                sc_reg[i]  <= sc_reg[i-1];
                pos_reg[i] <= pos_reg[i-1];
            end

            crcy_reg <= q_data.cr * q_data.cy;
            cysr_reg <= q_data.cy * q_data.sr;
            crsp_reg <= q_data.cr * q_data.sp;
            cpsr_reg <= q_data.cp * q_data.sr;
            cpcr_reg <= q_data.cp * q_data.cr;
            spsr_reg <= q_data.sp * q_data.sr;
            cysp_reg <= q_data.cy * q_data.sp;
            cpcy_reg <= q_data.cp * q_data.cy;
            sy1_reg  <= q_data.sy;

            crspsy_reg <= crsp_reg * sy1_reg;
            spsrsy_reg <= spsr_reg * sy1_reg;
            cpcrsy_reg <= cpcr_reg * sy1_reg;
            cpsrsy_reg <= cpsr_reg * sy1_reg;
            crcy2_reg  <= crcy_reg;
            cysr2_reg  <= cysr_reg;
            crsp2_reg  <= crsp_reg;
            cpsr2_reg  <= cpsr_reg;
            cpcr2_reg  <= cpcr_reg;
            spsr2_reg  <= spsr_reg;
            cysp2_reg  <= cysp_reg;
            cpcy2_reg  <= cpcy_reg;
            sy2_reg    <= sy1_reg;

            // terms carry 42 fraction bits
            term_reg[0] <= TERM_W'(crcy2_reg) <<< 14;
            term_reg[1] <= TERM_W'(cysr2_reg) <<< 14;
            term_reg[2] <= -(TERM_W'(sy2_reg) <<< 28);
            term_reg[3] <= TERM_W'(crspsy_reg) - (TERM_W'(cpsr2_reg) <<< 14);
            term_reg[4] <= (TERM_W'(cpcr2_reg) <<< 14) + TERM_W'(spsrsy_reg);
            term_reg[5] <= TERM_W'(cysp2_reg) <<< 14;
            term_reg[6] <= (TERM_W'(spsr2_reg) <<< 14) + TERM_W'(cpcrsy_reg);
            term_reg[7] <= TERM_W'(cpsrsy_reg) - (TERM_W'(crsp2_reg) <<< 14);
            term_reg[8] <= TERM_W'(cpcy2_reg) <<< 14;
        end
    end

    for (genvar e = 0; e < ELEMS; e++) begin : g_elem
        logic [TERM_W-1:0]  tmag;
        logic [TERM_W-1:0]  tsum;
        logic [RMAG_W-1:0]  mr;
        coord_t             sc;
        logic [SPROD_W-1:0] psum;
        logic [SMAG_W-1:0]  pmag;
        logic [SMAG_W-1:0]  lim;

        assign sc   = sc_reg[2][e/3];
        assign tmag = term_reg[e][TERM_W-1] ? TERM_W'(-term_reg[e]) : TERM_W'(term_reg[e]);
        assign tsum = tmag + TERM_W'(1 << 11);
        assign mr   = tsum[RMAG_W+11:12];
        assign psum = prod_reg[e] + SPROD_W'(1 << 29);
        assign pmag = psum[SPROD_W-1:30];
        assign lim  = neg5_reg[e] ? SMAG_W'(1) << (COORD_BITS - 1)
                                  : (SMAG_W'(1) << (COORD_BITS - 1)) - 1'b1;

        always_ff @(posedge aclk) begin
            if (en) begin
                mr_reg[e]   <= mr;
                rneg_reg[e] <= term_reg[e][TERM_W-1] && (mr != '0);
                ms_reg[e]   <= sc[COORD_BITS-1] ? COORD_BITS'(-sc) : COORD_BITS'(sc);
                sneg_reg[e] <= sc[COORD_BITS-1];

                prod_reg[e] <= SPROD_W'(ms_reg[e]) * SPROD_W'(mr_reg[e]);
                neg5_reg[e] <= sneg_reg[e] ^ rneg_reg[e];

                mag_reg[e]  <= (pmag > lim) ? lim[COORD_BITS-1:0] : pmag[COORD_BITS-1:0];
                neg6_reg[e] <= neg5_reg[e];

                el_reg[e]   <= neg6_reg[e] ? COORD_BITS'(-mag_reg[e]) : COORD_BITS'(mag_reg[e]);
            end
        end
    end

    assign m_data.elem_00 = el_reg[0];
    assign m_data.elem_01 = el_reg[1];
    assign m_data.elem_02 = el_reg[2];
    assign m_data.elem_04 = el_reg[3];
    assign m_data.elem_05 = el_reg[4];
    assign m_data.elem_06 = el_reg[5];
    assign m_data.elem_08 = el_reg[6];
    assign m_data.elem_09 = el_reg[7];
    assign m_data.elem_10 = el_reg[8];
    assign m_data.elem_12 = pos_reg[NST-1][0];
    assign m_data.elem_13 = pos_reg[NST-1][1];
    assign m_data.elem_14 = pos_reg[NST-1][2];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_data))
        else $error("stalled result word changed");
    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |=> v_reg[0])
        else $error("word taken from queue was lost");
    a_sat_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[5] && !neg6_reg[0]) |-> !mag_reg[0][COORD_BITS-1])
        else $error("positive element beyond range");

endmodule

/* tb/compose_trs_matrix_core_tb.sv */
`timescale 1ns / 100ps

module compose_trs_matrix_core_tb;
    import ctrs_pkg::*;

    localparam int N_RANDOM = 1600;
    localparam int LATENCY  = 24;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    ctrs_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    ctrs_out_t m_data;

    ctrs_out_t matrix_q[$];
    int        n_errors = 0;
    bit        feed_done = 1'b0;
    bit        hold_off = 1'b0;

    typedef struct {
        ctrs_in_t  xfm;
        bit        known;
        ctrs_out_t mat;
    } vec_t;

    compose_trs_matrix_core dut (.*);

    always #10 aclk = ~aclk;

    // arithmetic shift right rounding toward minus infinity
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint shr_round(longint v, int s);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic void cordic_sc(logic [15:0] ang, output longint sn, output longint cs);
        logic [31:0] z;
        bit          flip;
        longint      zi, x, y, dx, dy;
        z    = {ang, 16'h0};
        flip = (z[31:30] == 2'd1) || (z[31:30] == 2'd2);
        if (flip) z = z + 32'h80000000;
        zi = longint'(signed'(z));
        x  = 326016437;
        y  = 0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (zi >= 0) begin
                x -= dx; y += dy; zi -= longint'(ATAN_TURNS[i]);
            end else begin
                x += dx; y -= dy; zi += longint'(ATAN_TURNS[i]);
            end
        end
        cs = shr_round(x, 15);
        sn = shr_round(y, 15);
        if (cs > 16384) cs = 16384;
        if (cs < -16384) cs = -16384;
        if (sn > 16384) sn = 16384;
        if (sn < -16384) sn = -16384;
        if (flip) begin
            cs = -cs; sn = -sn;
        end
    endfunction

    function automatic coord_t scaled_elem(coord_t scale, longint term42);
        longint  r;
        longint  ms, mr, hi, lo, mag, lim;
        bit      neg;
        r   = shr_round(term42, 12);
        ms  = (scale < 0) ? -longint'(scale) : longint'(scale);
        mr  = (r < 0) ? -r : r;
        hi  = ms >>> 30;
        lo  = ms & ((64'sd1 <<< 30) - 1);
        mag = hi * mr + ((lo * mr + (64'sd1 <<< 29)) >>> 30);
        neg = (scale < 0) != (r < 0);
        lim = 64'sd1 <<< 31;
        if (!neg) lim -= 1;
        if (mag > lim) mag = lim;
        return neg ? coord_t'(-mag) : coord_t'(mag);
    endfunction

    function automatic ctrs_out_t trs_matrix(ctrs_in_t t);
        longint    sp, cp, sy, cy, sr, cr;
        longint    k;
        ctrs_out_t o;
        k = 16384;
        cordic_sc(t.pitch_angle, sp, cp);
        cordic_sc(t.yaw_angle, sy, cy);
        cordic_sc(t.roll_angle, sr, cr);
        o.elem_00 = scaled_elem(t.scale_x, cr * cy * k);
        o.elem_01 = scaled_elem(t.scale_x, cy * sr * k);
        o.elem_02 = scaled_elem(t.scale_x, -sy * k * k);
        o.elem_04 = scaled_elem(t.scale_y, cr * sp * sy - cp * sr * k);
        o.elem_05 = scaled_elem(t.scale_y, cp * cr * k + sp * sr * sy);
        o.elem_06 = scaled_elem(t.scale_y, cy * sp * k);
        o.elem_08 = scaled_elem(t.scale_z, sp * sr * k + cp * cr * sy);
        o.elem_09 = scaled_elem(t.scale_z, cp * sr * sy - cr * sp * k);
        o.elem_10 = scaled_elem(t.scale_z, cp * cy * k);
        o.elem_12 = t.pos_x;
        o.elem_13 = t.pos_y;
        o.elem_14 = t.pos_z;
        return o;
    endfunction

    function automatic ctrs_in_t mk_xfm(logic [15:0] p, logic [15:0] y, logic [15:0] r,
                                        coord_t sx, coord_t sy, coord_t sz,
                                        coord_t px, coord_t py, coord_t pz);
        ctrs_in_t t;
        t = '{p, y, r, sx, sy, sz, px, py, pz};
        return t;
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'(32'sh7fffffff);
            1: return coord_t'(32'sh80000000);
            2: return coord_t'($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 7)) << 13;
            1: return 16'($urandom_range(0, 3)) * 16'h4000 + 16'($urandom_range(0, 4)) - 16'd2;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_xfm(ctrs_in_t t);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        matrix_q.push_back(trs_matrix(t));
    endtask

    // zero angles: cosine reads 1.0, sine one LSB above zero after 14 stages
    function automatic ctrs_out_t plain_mat(coord_t a, coord_t b, coord_t c, coord_t d,
                                            coord_t e, coord_t f, coord_t g, coord_t h,
                                            coord_t i, coord_t px, coord_t py, coord_t pz);
        ctrs_out_t o;
        o = '{a, b, c, d, e, f, g, h, i, px, py, pz};
        return o;
    endfunction

    initial begin
        vec_t      dir[$];
        vec_t      v;
        ctrs_in_t  t;
        coord_t    one, mx, mn;
        one = 32'sh10000;
        mx  = 32'sh7fffffff;
        mn  = 32'sh80000000;

        v.known = 1'b1;
        v.xfm = mk_xfm(16'h0, 16'h0, 16'h0, one, one, one, 0, 0, 0);
        v.mat = plain_mat(one, 32'sh4, -32'sh4, -32'sh4, one, 32'sh4, 32'sh4, -32'sh4, one,
                          0, 0, 0);
        dir.push_back(v);
        v.xfm = mk_xfm(16'h0, 16'h0, 16'h0, 0, 0, 0, mx, mn, 32'sh1234);
        v.mat = plain_mat(0, 0, 0, 0, 0, 0, 0, 0, 0, mx, mn, 32'sh1234);
        dir.push_back(v);
        v.xfm = mk_xfm(16'h0, 16'h0, 16'h0, mx, mx, mx, mn, mx, -1);
        v.mat = plain_mat(mx, 32'sh20000, -32'sh20000, -32'sh1fff8, mx, 32'sh20000,
                          32'sh20008, -32'sh1fff8, mx, mn, mx, -1);
        dir.push_back(v);
        v.xfm = mk_xfm(16'h0, 16'h0, 16'h0, mn, mn, mn, 0, 0, 0);
        v.mat = plain_mat(mn, -32'sh20000, 32'sh20000, 32'sh1fff8, mn, -32'sh20000,
                          -32'sh20008, 32'sh1fff8, mn, 0, 0, 0);
        dir.push_back(v);
        v.known = 1'b0;
        for (int i = 0; i < 8; i++) begin
            logic [15:0] a;
            a = 16'(i) * 16'h2000 + ((i % 2) ? 16'hffff : 16'h0);
            v.xfm = mk_xfm(a, 16'h8000 - a, a ^ 16'h5555, one, -one, mx, i, -i, mn);
            dir.push_back(v);
        end
        v.xfm = mk_xfm(16'h7fff, 16'h8000, 16'hffff, mx, mn, mx, 0, 0, 0);
        dir.push_back(v);
        v.xfm = mk_xfm(16'h4000, 16'h4000, 16'h4000, mn, mx, mn, 0, 0, 0);
        dir.push_back(v);
        v.xfm = mk_xfm(16'hc000, 16'h1000, 16'h2000, 32'sh1, -1, 32'sh3, 0, 0, 0);
        dir.push_back(v);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir[i]) begin
            if (dir[i].known && dir[i].mat !== trs_matrix(dir[i].xfm)) begin
                $error("directed row %0d disagrees with predictor", i);
                n_errors++;
            end
            send_xfm(dir[i].xfm);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            t = mk_xfm(rand_angle(), rand_angle(), rand_angle(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), rand_coord(), rand_coord());
            send_xfm(t);
        end
        s_valid <= 1'b0;
        feed_done = 1'b1;
    end

    // long stall partway through so the pipeline and queue back up
    initial begin
        wait (aresetn);
        repeat (400) @(posedge aclk);
        hold_off = 1'b1;
        repeat (120) @(posedge aclk);
        hold_off = 1'b0;
    end

    initial begin
        int wait_n;
        ctrs_out_t e;
        wait (aresetn);
        forever begin
            wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
            if (wait_n != 0 || hold_off) begin
                m_ready <= 1'b0;
                repeat (wait_n) @(posedge aclk);
                while (hold_off) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (matrix_q.size() == 0) begin
                $error("result word with nothing expected");
                n_errors++;
            end else begin
                e = matrix_q.pop_front();
                if (m_data.elem_00 !== e.elem_00) begin
                    $error("elem_00 exp %h got %h", e.elem_00, m_data.elem_00); n_errors++; end
                if (m_data.elem_01 !== e.elem_01) begin
                    $error("elem_01 exp %h got %h", e.elem_01, m_data.elem_01); n_errors++; end
                if (m_data.elem_02 !== e.elem_02) begin
                    $error("elem_02 exp %h got %h", e.elem_02, m_data.elem_02); n_errors++; end
                if (m_data.elem_04 !== e.elem_04) begin
                    $error("elem_04 exp %h got %h", e.elem_04, m_data.elem_04); n_errors++; end
                if (m_data.elem_05 !== e.elem_05) begin
                    $error("elem_05 exp %h got %h", e.elem_05, m_data.elem_05); n_errors++; end
                if (m_data.elem_06 !== e.elem_06) begin
                    $error("elem_06 exp %h got %h", e.elem_06, m_data.elem_06); n_errors++; end
                if (m_data.elem_08 !== e.elem_08) begin
                    $error("elem_08 exp %h got %h", e.elem_08, m_data.elem_08); n_errors++; end
                if (m_data.elem_09 !== e.elem_09) begin
                    $error("elem_09 exp %h got %h", e.elem_09, m_data.elem_09); n_errors++; end
                if (m_data.elem_10 !== e.elem_10) begin
                    $error("elem_10 exp %h got %h", e.elem_10, m_data.elem_10); n_errors++; end
                if (m_data.elem_12 !== e.elem_12) begin
                    $error("elem_12 exp %h got %h", e.elem_12, m_data.elem_12); n_errors++; end
                if (m_data.elem_13 !== e.elem_13) begin
                    $error("elem_13 exp %h got %h", e.elem_13, m_data.elem_13); n_errors++; end
                if (m_data.elem_14 !== e.elem_14) begin
                    $error("elem_14 exp %h got %h", e.elem_14, m_data.elem_14); n_errors++; end
            end
        end
    end

    initial begin
        wait (feed_done);
        while (matrix_q.size() != 0) @(posedge aclk);
        repeat (LATENCY * 2) @(posedge aclk);
        if (n_errors == 0) begin
            $display("PASS compose_trs_matrix_core");
        end else begin
            $display("FAIL compose_trs_matrix_core");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("FAIL compose_trs_matrix_core");
        $finish;
    end

endmodule
